@@ rtl/core/mslg_pkg.sv @@
// Shared constants for the multi-stop linear gradient shader.
// Register indexes, opcodes, tile modes and Q16.16 constants; no dependencies.
package mslg_pkg;

  localparam int MAX_STOPS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int ONE_Q16       = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X      = 3'd0,
    CFG_COEF_Y      = 3'd1,
    CFG_COEF_OFFSET = 3'd2,
    CFG_TILE_MODE   = 3'd3,
    CFG_STOP_COUNT  = 3'd4
  } cfg_index_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  localparam logic [1:0] TILE_CLAMP  = 2'd0;
  localparam logic [1:0] TILE_REPEAT = 2'd1;
  localparam logic [1:0] TILE_MIRROR = 2'd2;

endpackage

@@ rtl/core/mslg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low; no dependencies.
module mslg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/multi_stop_linear_gradient_top.sv @@
// Multi-stop linear gradient shader: gradient parameter, tiling, stop lookup,
// interpolation and premultiply. Uses mslg_pkg and two mslg_ram stop tables.
//
// The block accepts one item per clock, load or shade, and sustains that rate
// as long as the pixel output is not stalled; a stall on the output freezes the
// whole pipeline and raises item_stall in the same cycle. A shade item yields
// one ARGB pixel after gradient multiply, sum, tile, table read, interpolate,
// premultiply and rounding divide; a load item yields nothing and writes its
// stop at the table-read stage, in item order, so a shade that follows a load
// sees the new stop. The stop table is held twice so both segment ends are read
// at once. Stops must be loaded before any shade uses them; the user must write
// configuration only while the pipeline is empty; the block never enforces it.
module multi_stop_linear_gradient_top #(
  parameter int MAX_STOPS = mslg_pkg::MAX_STOPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mslg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           opcode,
  input  logic [11:0]                    pixel_x,
  input  logic [11:0]                    pixel_y,
  input  logic                           span_end,
  input  logic [3:0]                     stop_index,
  input  logic [7:0]                     stop_red,
  input  logic [7:0]                     stop_green,
  input  logic [7:0]                     stop_blue,
  input  logic [7:0]                     stop_alpha,
  output logic                           pixel_valid,
  input  logic                           pixel_stall,
  output logic [7:0]                     out_alpha,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_span_end
);

  import mslg_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int PW = 17 + AW;

  logic signed [31:0] coef_x;
  logic signed [31:0] coef_y;
  logic signed [31:0] coef_offset;
  logic [1:0]         tile_mode;
  logic [4:0]         stop_count;

  logic en;
  assign en         = !(pixel_valid && pixel_stall);
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  // stage 1: gradient products
  logic               s1_valid, s1_shade, s1_span;
  logic [3:0]         s1_index;
  logic [31:0]        s1_color;
  logic signed [45:0] s1_px, s1_py;
  // stage 2: sum
  logic               s2_valid, s2_shade, s2_span;
  logic [3:0]         s2_index;
  logic [31:0]        s2_color;
  logic signed [47:0] s2_sum;
  // stage 3: tiled t, table access
  logic               s3_valid, s3_shade, s3_span;
  logic [3:0]         s3_index;
  logic [31:0]        s3_color;
  logic [16:0]        s3_tiled;
  // stage 4: table data
  logic               s4_valid, s4_span;
  logic [15:0]        s4_f;
  logic [31:0]        rd0, rd1;
  // stage 5: interpolated channels, R G B A
  logic               s5_valid, s5_span;
  logic [23:0]        s5_ch [4];
  // stage 6: premultiply products
  logic               s6_valid, s6_span;
  logic [7:0]         s6_alpha;
  logic [47:0]        s6_prod [3];

  logic signed [45:0] mul_x, mul_y;
  assign mul_x = 46'(coef_x) * 46'($signed({1'b0, pixel_x, 1'b1}));
  assign mul_y = 46'(coef_y) * 46'($signed({1'b0, pixel_y, 1'b1}));

  logic signed [46:0] t_q;
  logic [15:0]        t_frac;
  logic [16:0]        tiled_next;
  assign t_q    = s2_sum[47:1];
  assign t_frac = t_q[15:0];

  always_comb begin
    case (tile_mode)
      TILE_REPEAT: tiled_next = {1'b0, t_frac};
      TILE_MIRROR: tiled_next = t_q[16] ? 17'(ONE_Q16) - {1'b0, t_frac} : {1'b0, t_frac};
      default: begin
        if (t_q[46]) begin
          tiled_next = '0;
        end else if (t_q[45:0] > 46'(ONE_Q16)) begin
          tiled_next = 17'(ONE_Q16);
        end else begin
          tiled_next = t_q[16:0];
        end
      end
    endcase
  end

  logic [8:0]    cnt9, n9;
  logic [AW-1:0] nm1;
  always_comb begin
    cnt9 = 9'(stop_count);
    if (cnt9 < 9'd2) begin
      n9 = 9'd2;
    end else if (cnt9 > 9'(MAX_STOPS)) begin
      n9 = 9'(MAX_STOPS);
    end else begin
      n9 = cnt9;
    end
  end
  assign nm1 = AW'(n9 - 9'd1);

  logic [PW-1:0] seg_p;
  logic [AW:0]   seg_idx;
  logic          seg_last;
  logic [AW-1:0] raddr0, raddr1;
  logic [15:0]   f_next;
  assign seg_p    = PW'(s3_tiled) * PW'(nm1);
  assign seg_idx  = seg_p[PW-1:16];
  assign seg_last = seg_idx >= {1'b0, nm1};
  assign raddr0   = seg_last ? nm1 : seg_idx[AW-1:0];
  assign raddr1   = seg_idx[AW-1:0] + AW'(1);
  assign f_next   = seg_last ? 16'd0 : seg_p[15:0];

  logic [8:0]    windex;
  logic          ram_we;
  assign windex = 9'(s3_index);
  assign ram_we = en && s3_valid && !s3_shade && (windex < 9'(MAX_STOPS));

  mslg_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_ram0 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (windex[AW-1:0]),
    .wdata (s3_color),
    .re    (en),
    .raddr (raddr0),
    .rdata (rd0)
  );

  mslg_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_ram1 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (windex[AW-1:0]),
    .wdata (s3_color),
    .re    (en),
    .raddr (raddr1),
    .rdata (rd1)
  );

  logic [16:0] w0;
  logic [23:0] ch_next [4];
  assign w0 = 17'(ONE_Q16) - {1'b0, s4_f};
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ch_next[k] = 24'(25'(rd0[31-8*k -: 8]) * 25'(w0) + 25'(rd1[31-8*k -: 8]) * 25'(s4_f));
    end
  end

  logic [48:0] pm_q   [3];
  logic [16:0] pm_h   [3];
  logic [16:0] pm_v   [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pm_q[k] = 49'(s6_prod[k]) + (49'(255) << 31);
      pm_h[k] = pm_q[k][48:32];
      pm_v[k] = (pm_h[k] + (pm_h[k] >> 8) + 17'd1) >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x      <= '0;
      coef_y      <= '0;
      coef_offset <= '0;
      tile_mode   <= TILE_CLAMP;
      stop_count  <= 5'd2;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      s5_valid    <= 1'b0;
      s6_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COEF_X:      coef_x      <= cfg_data;
          CFG_COEF_Y:      coef_y      <= cfg_data;
          CFG_COEF_OFFSET: coef_offset <= cfg_data;
          CFG_TILE_MODE:   tile_mode   <= cfg_data[1:0];
          CFG_STOP_COUNT:  stop_count  <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (en) begin
        s1_valid    <= item_valid;
        s2_valid    <= s1_valid;
        s3_valid    <= s2_valid;
        s4_valid    <= s3_valid && s3_shade;
        s5_valid    <= s4_valid;
        s6_valid    <= s5_valid;
        pixel_valid <= s6_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_shade <= (opcode == OP_SHADE);
      s1_span  <= span_end;
      s1_index <= stop_index;
      s1_color <= {stop_red, stop_green, stop_blue, stop_alpha};
      s1_px    <= mul_x;
      s1_py    <= mul_y;

      s2_shade <= s1_shade;
      s2_span  <= s1_span;
      s2_index <= s1_index;
      s2_color <= s1_color;
      s2_sum   <= 48'(s1_px) + 48'(s1_py) + (48'(coef_offset) <<< 1);

      s3_shade <= s2_shade;
      s3_span  <= s2_span;
      s3_index <= s2_index;
      s3_color <= s2_color;
      s3_tiled <= tiled_next;

      s4_span  <= s3_span;
      s4_f     <= f_next;

      s5_span  <= s4_span;
      for (int k = 0; k < 4; k++) begin
        s5_ch[k] <= ch_next[k];
      end

      s6_span  <= s5_span;
      s6_alpha <= 8'((25'(s5_ch[3]) + 25'd32768) >> 16);
      for (int k = 0; k < 3; k++) begin
        s6_prod[k] <= 48'(s5_ch[k]) * 48'(s5_ch[3]);
      end

      out_span_end <= s6_span;
      out_alpha    <= s6_alpha;
      out_red      <= pm_v[0][7:0];
      out_green    <= pm_v[1][7:0];
      out_blue     <= pm_v[2][7:0];
    end
  end

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_stall) |=> ($stable(s6_valid) && $stable(s6_alpha)))
    else $error("pipeline advanced while output stalled");

  a_tiled_range: assert property (@(posedge clk) disable iff (rst)
    (en && s2_valid) |=> (s3_tiled <= 17'(ONE_Q16)))
    else $error("tiled gradient parameter above one");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_shade) |-> (raddr0 <= nm1 && (seg_last || raddr1 <= nm1)))
    else $error("stop table read outside used stops");

endmodule

@@ bench/multi_stop_linear_gradient_top_tb.sv @@
// Self-checking bench for multi_stop_linear_gradient_top: stop loads, shaded pixels,
// and all tile modes under random bursts and output stalls, checked against a local model.
// Depends on mslg_pkg and the multi_stop_linear_gradient_top RTL.
module multi_stop_linear_gradient_top_tb;
  import mslg_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 122;
  localparam int HOLD_AT         = 300;
  localparam int LONG_HOLD       = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [1:0] TILE_UNUSED = 2'd3;

  typedef struct {
    logic       op;
    logic [11:0] x;
    logic [11:0] y;
    logic       last;
    logic [3:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } gradient_item_t;

  typedef struct {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } argb_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic opcode = 1'b0;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic span_end = 1'b0;
  logic [3:0] stop_index = '0;
  logic [7:0] stop_red = '0;
  logic [7:0] stop_green = '0;
  logic [7:0] stop_blue = '0;
  logic [7:0] stop_alpha = '0;
  logic pixel_valid;
  logic pixel_stall = 1'b0;
  logic [7:0] out_alpha;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic out_span_end;

  multi_stop_linear_gradient_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .opcode(opcode), .pixel_x(pixel_x), .pixel_y(pixel_y), .span_end(span_end),
    .stop_index(stop_index), .stop_red(stop_red), .stop_green(stop_green),
    .stop_blue(stop_blue), .stop_alpha(stop_alpha),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .out_alpha(out_alpha), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_span_end(out_span_end)
  );

  logic signed [31:0] sh_coef_x = '0;
  logic signed [31:0] sh_coef_y = '0;
  logic signed [31:0] sh_coef_offset = '0;
  logic [1:0] sh_tile_mode = TILE_CLAMP;
  logic [4:0] sh_stop_count = 5'd2;
  logic [31:0] stop_colors [MAX_STOPS_DEF];

  gradient_item_t pending_items[$];
  argb_pixel_t expected_pixels[$];

  bit item_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int pixels_seen = 0;
  int bad_pixels = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < MAX_STOPS_DEF; i++) stop_colors[i] = '0;
  end

  function automatic logic [7:0] premul8(input logic [63:0] c, input logic [63:0] a);
    logic [63:0] den;
    logic [63:0] v;
    den = 64'd255 << 32;
    v = (c * a + (den >> 1)) / den;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic argb_pixel_t shade_pixel(input logic [11:0] px, input logic [11:0] py,
                                              input logic last);
    logic signed [63:0] cx, cy, off, xs, ys, t;
    logic [16:0] tiled;
    logic [63:0] tw, nm1, p, seg, f;
    logic [31:0] e0, e1;
    logic [63:0] ch [4];
    argb_pixel_t res;
    cx = sh_coef_x;
    cy = sh_coef_y;
    off = sh_coef_offset;
    xs = {51'd0, px, 1'b1};
    ys = {51'd0, py, 1'b1};
    t = (cx * xs + cy * ys + (off <<< 1)) >>> 1;
    case (sh_tile_mode)
      TILE_REPEAT: tiled = {1'b0, t[15:0]};
      TILE_MIRROR: tiled = t[16] ? 17'(ONE_Q16) - {1'b0, t[15:0]} : {1'b0, t[15:0]};
      default: begin
        if (t < 0) tiled = '0;
        else if (t > ONE_Q16) tiled = 17'(ONE_Q16);
        else tiled = t[16:0];
      end
    endcase
    if (sh_stop_count < 5'd2) nm1 = 64'd1;
    else if (sh_stop_count > 5'(MAX_STOPS_DEF)) nm1 = 64'(MAX_STOPS_DEF - 1);
    else nm1 = 64'(sh_stop_count) - 64'd1;
    tw = 64'(tiled);
    p = tw * nm1;
    seg = p >> 16;
    f = p & 64'hFFFF;
    if (seg >= nm1) begin
      e0 = stop_colors[nm1[3:0]];
      for (int k = 0; k < 4; k++) ch[k] = 64'(e0[(24 - 8 * k) +: 8]) << 16;
    end else begin
      e0 = stop_colors[seg[3:0]];
      e1 = stop_colors[seg[3:0] + 4'd1];
      for (int k = 0; k < 4; k++)
        ch[k] = 64'(e0[(24 - 8 * k) +: 8]) * (64'(ONE_Q16) - f) + 64'(e1[(24 - 8 * k) +: 8]) * f;
    end
    res.alpha = 8'((ch[3] + 64'd32768) >> 16);
    res.red   = premul8(ch[0], ch[3]);
    res.green = premul8(ch[1], ch[3]);
    res.blue  = premul8(ch[2], ch[3]);
    res.last  = last;
    return res;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sender: bursts of random length, random gaps between them unless gap_max is zero
  always @(negedge clk) begin
    gradient_item_t cur;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur = pending_items.pop_front();
        opcode <= cur.op;
        pixel_x <= cur.x;
        pixel_y <= cur.y;
        span_end <= cur.last;
        stop_index <= cur.index;
        stop_red <= cur.red;
        stop_green <= cur.green;
        stop_blue <= cur.blue;
        stop_alpha <= cur.alpha;
        item_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0 && gap_max != 0) gap_left = $urandom_range(1, gap_max);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pixel_stall <= 1'b1;
    end else if (!hold_used && pixels_seen >= HOLD_AT) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
      pixel_stall <= 1'b1;
    end else begin
      pixel_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    argb_pixel_t want;
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          bad_pixels++;
          if (bad_pixels <= 10)
            $display("unexpected pixel: a=%0d r=%0d g=%0d b=%0d end=%0b",
                     out_alpha, out_red, out_green, out_blue, out_span_end);
        end else begin
          want = expected_pixels.pop_front();
          if (out_alpha !== want.alpha || out_red !== want.red || out_green !== want.green ||
              out_blue !== want.blue || out_span_end !== want.last) begin
            bad_pixels++;
            if (bad_pixels <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                       want.alpha, want.red, want.green, want.blue, want.last,
                       out_alpha, out_red, out_green, out_blue, out_span_end);
          end
        end
      end
      if (item_valid && !item_stall) begin
        item_taken = 1'b1;
        if (opcode == OP_LOAD)
          stop_colors[stop_index] = {stop_red, stop_green, stop_blue, stop_alpha};
        else
          expected_pixels.push_back(shade_pixel(pixel_x, pixel_y, span_end));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COEF_X:      sh_coef_x = val;
      CFG_COEF_Y:      sh_coef_y = val;
      CFG_COEF_OFFSET: sh_coef_offset = val;
      CFG_TILE_MODE:   sh_tile_mode = val[1:0];
      CFG_STOP_COUNT:  sh_stop_count = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_load(input logic [3:0] idx, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a);
    gradient_item_t it;
    it.op = OP_LOAD;
    it.x = 12'($urandom);
    it.y = 12'($urandom);
    it.last = 1'($urandom);
    it.index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.alpha = a;
    pending_items.push_back(it);
  endtask

  task automatic push_shade(input logic [11:0] px, input logic [11:0] py, input logic last);
    gradient_item_t it;
    it.op = OP_SHADE;
    it.x = px;
    it.y = py;
    it.last = last;
    it.index = 4'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    it.alpha = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] off, input logic [1:0] mode,
                               input logic [4:0] count);
    write_reg(CFG_COEF_X, cx);
    write_reg(CFG_COEF_Y, cy);
    write_reg(CFG_COEF_OFFSET, off);
    write_reg(CFG_TILE_MODE, {30'd0, mode});
    write_reg(CFG_STOP_COUNT, {27'd0, count});
  endtask

  task automatic queue_random_items(input int count);
    int made;
    int roll;
    int len;
    logic [11:0] x0;
    logic [11:0] row;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_load(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        made++;
      end else if (roll < 14) begin
        push_shade(12'($urandom), 12'($urandom), 1'($urandom));
        made++;
      end else begin
        len = $urandom_range(1, 16);
        row = 12'($urandom);
        x0 = 12'($urandom_range(0, 4096 - len));
        for (int j = 0; j < len; j++) push_shade(x0 + 12'(j), row, j == len - 1);
        made += len;
      end
    end
  endtask

  initial begin
    int stall_choice [5] = '{0, 10, 30, 60, 85};
    int gap_choice [4] = '{0, 2, 5, 12};
    logic [31:0] cx, cy, off;
    logic [1:0] mode;
    logic [4:0] count;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the table so no shade reads an unloaded stop
    for (int i = 0; i < MAX_STOPS_DEF; i++) begin
      if (i == 0) push_load(4'(i), 8'd0, 8'd0, 8'd0, 8'd0);
      else if (i == MAX_STOPS_DEF - 1) push_load(4'(i), 8'd255, 8'd255, 8'd255, 8'd255);
      else if (i == 1) push_load(4'(i), 8'd255, 8'd0, 8'd255, 8'd255);
      else push_load(4'(i), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    push_shade(12'd0, 12'd0, 1'b0);
    push_shade(12'd4095, 12'd4095, 1'b1);
    wait_idle();

    write_setting(32'd16, 32'd16, 32'd0, TILE_CLAMP, 5'd16);
    push_shade(12'd0, 12'd4095, 1'b0);
    push_shade(12'd4095, 12'd0, 1'b1);
    wait_idle();

    // t of exactly one selects the last stop; then a half-way blend of two stops
    write_setting(32'd0, 32'd0, 32'h0001_0000, TILE_CLAMP, 5'd16);
    push_shade(12'd100, 12'd200, 1'b1);
    wait_idle();
    write_reg(CFG_STOP_COUNT, 32'd2);
    write_reg(CFG_COEF_OFFSET, 32'h0000_8000);
    push_shade(12'd7, 12'd9, 1'b0);
    wait_idle();

    // mirror with odd and negative whole parts
    write_setting(32'd0, 32'd0, 32'h0001_4000, TILE_MIRROR, 5'd5);
    push_shade(12'd1, 12'd2, 1'b0);
    wait_idle();
    write_reg(CFG_COEF_OFFSET, 32'hFFFF_8000);
    push_shade(12'd3, 12'd4, 1'b1);
    wait_idle();

    // unused tile mode, stop counts out of range, register index past the list
    write_setting(32'd40, 32'hFFFF_FFD0, 32'h0000_4000, TILE_UNUSED, 5'd0);
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    push_shade(12'd2000, 12'd100, 1'b0);
    wait_idle();
    write_reg(CFG_STOP_COUNT, 32'd31);
    write_reg(CFG_TILE_MODE, {30'd0, TILE_REPEAT});
    push_shade(12'd2048, 12'd1024, 1'b1);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        cx = 32'h7FFF_FFFF; cy = 32'h8000_0000; off = 32'h7FFF_FFFF;
        mode = TILE_REPEAT; count = 5'd16;
      end else if (ph == 1) begin
        cx = 32'h8000_0000; cy = 32'h7FFF_FFFF; off = 32'h8000_0000;
        mode = TILE_MIRROR; count = 5'd2;
      end else if (ph == 2) begin
        cx = $urandom; cy = $urandom; off = $urandom;
        mode = 2'($urandom); count = 5'($urandom);
      end else begin
        cx = 32'($urandom_range(0, 512)) - 32'd256;
        cy = 32'($urandom_range(0, 512)) - 32'd256;
        off = 32'($urandom_range(0, 4 * ONE_Q16)) - 32'(2 * ONE_Q16);
        mode = 2'($urandom_range(0, 3));
        count = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(2, 16));
      end
      write_setting(cx, cy, off, mode, count);
      stall_pct = (ph == 3) ? 0 : stall_choice[$urandom_range(0, 4)];
      gap_max = (ph == 3) ? 0 : gap_choice[$urandom_range(0, 3)];
      queue_random_items(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (bad_pixels == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mslg_pkg.sv
rtl/core/mslg_ram.sv
rtl/core/multi_stop_linear_gradient_top.sv
bench/multi_stop_linear_gradient_top_tb.sv
